// File: rtl/osfc_pkg.sv
// Shared types, constants and fixed-point helpers for the observer/state-feedback controller.
package osfc_pkg;

  localparam int STATE_COUNT  = 3;
  localparam int OUTPUT_INDEX = 0;
  localparam int FRAC_BITS    = 16;
  localparam int MODEL_FRAC   = 24;
  localparam int DATA_W       = 32;
  localparam int ACC_W        = 64;
  localparam int STEP_W       = 5;

  localparam logic [STEP_W-1:0] OP_COUNT  = 5'd19;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

  localparam logic signed [ACC_W-1:0] FRAC_HALF  = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] MODEL_HALF = ACC_W'(64'sd1 <<< (MODEL_FRAC - 1));

  // Q7.24 plant model
  localparam logic signed [DATA_W-1:0] MODEL_A [STATE_COUNT][STATE_COUNT] = '{
    '{32'sd16805737,  32'sd161061,    32'sd3355},
    '{32'sd5561647,   32'sd15349475,  32'sd411042},
    '{-32'sd2816895,  -32'sd11286033, 32'sd845572}
  };
  localparam logic signed [DATA_W-1:0] MODEL_B [STATE_COUNT] = '{
    32'sd8053, 32'sd2023332, 32'sd38283929
  };

  // register map
  typedef enum logic [2:0] {
    REG_FB_GAIN0  = 3'd0,
    REG_FB_GAIN1  = 3'd1,
    REG_FB_GAIN2  = 3'd2,
    REG_CMD_GAIN  = 3'd3,
    REG_OBS_GAIN0 = 3'd4,
    REG_OBS_GAIN1 = 3'd5,
    REG_OBS_GAIN2 = 3'd6
  } reg_idx_t;

  localparam logic signed [DATA_W-1:0] OBS_GAIN0_RST = 32'sd95453;
  localparam logic signed [DATA_W-1:0] OBS_GAIN1_RST = 32'sd3179682;
  localparam logic signed [DATA_W-1:0] OBS_GAIN2_RST = -32'sd2525017;

  typedef enum logic [2:0] {
    ASRC_MODEL_B = 3'd0,
    ASRC_MODEL_A = 3'd1,
    ASRC_OBS     = 3'd2,
    ASRC_CMD     = 3'd3,
    ASRC_FB      = 3'd4
  } a_src_t;

  typedef enum logic [2:0] {
    BSRC_DRIVE = 3'd0,
    BSRC_EST   = 3'd1,
    BSRC_INNOV = 3'd2,
    BSRC_CMD   = 3'd3,
    BSRC_NEW   = 3'd4
  } b_src_t;

  typedef enum logic [2:0] {
    MODE_NONE  = 3'd0,
    MODE_LOAD  = 3'd1,  // acc = p
    MODE_ADD   = 3'd2,  // acc += p
    MODE_FIN   = 3'd3,  // acc = rnd24(acc) + rndF(p)
    MODE_LOADR = 3'd4,  // acc = rndF(p)
    MODE_SUBR  = 3'd5   // acc -= rndF(p)
  } acc_mode_t;

  typedef struct packed {
    a_src_t    asrc;
    b_src_t    bsrc;
    logic [1:0] row;
    logic [1:0] col;
    acc_mode_t mode;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic op_t op_decode(input logic [STEP_W-1:0] step);
    op_t op;
    op = '{asrc: ASRC_MODEL_B, bsrc: BSRC_DRIVE, row: 2'd0, col: 2'd0, mode: MODE_NONE};
    unique case (step)
      5'd0:  op = '{ASRC_MODEL_B, BSRC_DRIVE, 2'd0, 2'd0, MODE_LOAD};
      5'd1:  op = '{ASRC_MODEL_A, BSRC_EST,   2'd0, 2'd0, MODE_ADD};
      5'd2:  op = '{ASRC_MODEL_A, BSRC_EST,   2'd0, 2'd1, MODE_ADD};
      5'd3:  op = '{ASRC_MODEL_A, BSRC_EST,   2'd0, 2'd2, MODE_ADD};
      5'd4:  op = '{ASRC_OBS,     BSRC_INNOV, 2'd0, 2'd0, MODE_FIN};
      5'd5:  op = '{ASRC_MODEL_B, BSRC_DRIVE, 2'd1, 2'd0, MODE_LOAD};
      5'd6:  op = '{ASRC_MODEL_A, BSRC_EST,   2'd1, 2'd0, MODE_ADD};
      5'd7:  op = '{ASRC_MODEL_A, BSRC_EST,   2'd1, 2'd1, MODE_ADD};
      5'd8:  op = '{ASRC_MODEL_A, BSRC_EST,   2'd1, 2'd2, MODE_ADD};
      5'd9:  op = '{ASRC_OBS,     BSRC_INNOV, 2'd1, 2'd0, MODE_FIN};
      5'd10: op = '{ASRC_MODEL_B, BSRC_DRIVE, 2'd2, 2'd0, MODE_LOAD};
      5'd11: op = '{ASRC_MODEL_A, BSRC_EST,   2'd2, 2'd0, MODE_ADD};
      5'd12: op = '{ASRC_MODEL_A, BSRC_EST,   2'd2, 2'd1, MODE_ADD};
      5'd13: op = '{ASRC_MODEL_A, BSRC_EST,   2'd2, 2'd2, MODE_ADD};
      5'd14: op = '{ASRC_OBS,     BSRC_INNOV, 2'd2, 2'd0, MODE_FIN};
      5'd15: op = '{ASRC_CMD,     BSRC_CMD,   2'd0, 2'd0, MODE_LOADR};
      5'd16: op = '{ASRC_FB,      BSRC_NEW,   2'd0, 2'd0, MODE_SUBR};
      5'd17: op = '{ASRC_FB,      BSRC_NEW,   2'd1, 2'd0, MODE_SUBR};
      5'd18: op = '{ASRC_FB,      BSRC_NEW,   2'd2, 2'd0, MODE_SUBR};
      default: op.mode = MODE_NONE;
    endcase
    return op;
  endfunction

  // round to nearest, ties up
  function automatic logic signed [ACC_W-1:0] rnd_frac(input logic signed [ACC_W-1:0] v);
    return (v + FRAC_HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd_model(input logic signed [ACC_W-1:0] v);
    return (v + MODEL_HALF) >>> MODEL_FRAC;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -ACC_W'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/observer_state_feedback_controller.sv
// Top level: Luenberger observer with state feedback on one shared 32x32 multiplier.
// The result is loaded into the output register when the step sequence for an input beat ends.
// A new item is taken only after the last has finished, as the 19 products share the one multiplier.
// Input stall is high while an item is in work and while a finished result waits for a
// full output register. Reset (synchronous, rst_n low) clears the estimates, loads the
// register reset values and empties the output register.
module observer_state_feedback_controller
  import osfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_measured,
  input  logic signed [DATA_W-1:0] in_applied_drive,
  input  logic signed [DATA_W-1:0] in_setpoint,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_control_effort,
  output logic signed [DATA_W-1:0] out_est_state0,
  output logic signed [DATA_W-1:0] out_est_state1,
  output logic signed [DATA_W-1:0] out_est_state2,
  output logic signed [DATA_W-1:0] out_innovation,
  input  logic                     cfg_wr_en,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_wr_data
);

  localparam logic [1:0] OUT_IDX = 2'(OUTPUT_INDEX % STATE_COUNT);

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [DATA_W-1:0] fb_gain_r [STATE_COUNT];
  logic signed [DATA_W-1:0] obs_gain_r [STATE_COUNT];
  logic signed [DATA_W-1:0] cmd_gain_r;
  logic signed [DATA_W-1:0] est_r [STATE_COUNT];
  logic signed [DATA_W-1:0] new_r [STATE_COUNT];
  logic signed [DATA_W-1:0] drive_r, cmd_r, innov_r;
  logic signed [ACC_W-1:0]  prod_r, acc_r, acc_nxt;
  acc_mode_t                arr_mode_r;
  logic                     fin_vld_r;
  logic [1:0]               fin_row_r, arr_row_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_effort_r, out_innov_r;
  logic signed [DATA_W-1:0] out_est_r [STATE_COUNT];

  op_t                      op;
  logic                     issue, accept, finish;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0]  innov_wide, prod_w;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign finish   = (state_r == ST_RUN) && (step_r == LAST_STEP) && (!out_valid_r || !out_stall);
  assign issue    = (state_r == ST_RUN) && (step_r < OP_COUNT);
  assign op       = op_decode(step_r);

  assign innov_wide = ACC_W'(in_measured) - ACC_W'(est_r[OUT_IDX]);
  assign prod_w     = mul_a * mul_b;

  always_comb begin
    unique case (op.asrc)
      ASRC_MODEL_B: mul_a = MODEL_B[op.row];
      ASRC_MODEL_A: mul_a = MODEL_A[op.row][op.col];
      ASRC_OBS:     mul_a = obs_gain_r[op.row];
      ASRC_CMD:     mul_a = cmd_gain_r;
      ASRC_FB:      mul_a = fb_gain_r[op.row];
      default:      mul_a = '0;
    endcase
    unique case (op.bsrc)
      BSRC_DRIVE: mul_b = drive_r;
      BSRC_EST:   mul_b = est_r[op.col];
      BSRC_INNOV: mul_b = innov_r;
      BSRC_CMD:   mul_b = cmd_r;
      BSRC_NEW:   mul_b = new_r[op.row];
      default:    mul_b = '0;
    endcase
  end

  always_comb begin
    unique case (arr_mode_r)
      MODE_LOAD:  acc_nxt = prod_r;
      MODE_ADD:   acc_nxt = acc_r + prod_r;
      MODE_FIN:   acc_nxt = rnd_model(acc_r) + rnd_frac(prod_r);
      MODE_LOADR: acc_nxt = rnd_frac(prod_r);
      MODE_SUBR:  acc_nxt = acc_r - rnd_frac(prod_r);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end else if (step_r != LAST_STEP) begin
          step_nxt = step_r + 5'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      arr_mode_r  <= MODE_NONE;
      fin_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STATE_COUNT; i++) begin
        est_r[i]     <= '0;
        fb_gain_r[i] <= '0;
      end
      cmd_gain_r    <= '0;
      obs_gain_r[0] <= OBS_GAIN0_RST;
      obs_gain_r[1] <= OBS_GAIN1_RST;
      obs_gain_r[2] <= OBS_GAIN2_RST;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      arr_mode_r <= issue ? op.mode : MODE_NONE;
      fin_vld_r  <= (arr_mode_r == MODE_FIN);

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_FB_GAIN0:  fb_gain_r[0]  <= cfg_wr_data;
          REG_FB_GAIN1:  fb_gain_r[1]  <= cfg_wr_data;
          REG_FB_GAIN2:  fb_gain_r[2]  <= cfg_wr_data;
          REG_CMD_GAIN:  cmd_gain_r    <= cfg_wr_data;
          REG_OBS_GAIN0: obs_gain_r[0] <= cfg_wr_data;
          REG_OBS_GAIN1: obs_gain_r[1] <= cfg_wr_data;
          REG_OBS_GAIN2: obs_gain_r[2] <= cfg_wr_data;
          default: ;
        endcase
      end

      if (finish) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < STATE_COUNT; i++) begin
          est_r[i] <= new_r[i];
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      drive_r <= in_applied_drive;
      cmd_r   <= in_setpoint;
      innov_r <= sat32(innov_wide);
    end
    prod_r    <= prod_w;
    acc_r     <= acc_nxt;
    arr_row_r <= op.row;
    fin_row_r <= arr_row_r;
    if (fin_vld_r) begin
      new_r[fin_row_r] <= sat32(acc_r);
    end
    if (finish) begin
      out_effort_r <= sat32(acc_r);
      out_innov_r  <= innov_r;
      for (int i = 0; i < STATE_COUNT; i++) begin
        out_est_r[i] <= new_r[i];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_control_effort = out_effort_r;
  assign out_est_state0     = out_est_r[0];
  assign out_est_state1     = out_est_r[1];
  assign out_est_state2     = out_est_r[2];
  assign out_innovation     = out_innov_r;

endmodule

// File: rtl/osfc_chk.sv
// Port-level checker for the observer/state-feedback controller, bound to the top level.
module osfc_chk
  import osfc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_control_effort,
  input logic signed [DATA_W-1:0] out_est_state0
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_control_effort)
      && $stable(out_est_state0))
    else $error("stalled result beat changed");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // no result rises in the cycle after an input beat
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##1 !$rose(out_valid))
    else $error("result appeared too early");

  // a new result shows up exactly when the block frees its input
  a_done_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $fell(in_stall))
    else $error("result without end of work");

endmodule

bind observer_state_feedback_controller osfc_chk u_osfc_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_control_effort (out_control_effort),
  .out_est_state0     (out_est_state0)
);
